@@ hdl/matinv_pkg.sv @@
// Shared widths and types for the 3x3 matrix inverse pipeline.
// No dependencies; used by matinv_div and matrix_inverse_3x3_core.
`timescale 1ns / 1ps
package matinv_pkg;

  localparam int IN_W    = 16;  // Q4.12 matrix entry
  localparam int PROD_W  = 32;  // product of two entries
  localparam int ADJ_W   = 33;  // cofactor, Q9.24
  localparam int DET_W   = 50;  // determinant, Q14.36
  localparam int NMAG_W  = 32;  // cofactor magnitude
  localparam int DMAG_W  = 49;  // determinant magnitude
  localparam int FRAC_SH = 29;  // numerator scale
  localparam int NUM_W   = 61;  // dividend width, one pipeline step per bit
  localparam int DEN_W   = 50;  // divisor width (twice the determinant magnitude)
  localparam int Q_W     = 33;  // kept quotient bits
  localparam int OUT_W   = 32;  // Q16.16 result entry
  localparam int NLANE   = 9;
  localparam int NPROD   = 18;

  localparam logic [Q_W-1:0]   POS_LIM = Q_W'(33'h07FFFFFFF);
  localparam logic [Q_W-1:0]   NEG_LIM = Q_W'(33'h080000000);
  localparam logic [OUT_W-1:0] POS_MAX = 32'h7FFFFFFF;
  localparam logic [OUT_W-1:0] NEG_MIN = 32'h80000000;

  typedef logic signed [IN_W-1:0]   ent_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [NUM_W-1:0]         num_t;
  typedef logic [DEN_W-1:0]         den_t;
  typedef logic [Q_W-1:0]           quo_t;
  typedef logic signed [OUT_W-1:0]  res_t;

  typedef struct packed {
    logic             singular;
    logic [NLANE-1:0] neg;
  } side_t;

endpackage

@@ hdl/matinv_div.sv @@
// Nine-lane pipelined restoring divider, one quotient bit per stage.
// Depends on matinv_pkg; divisor pipe is shared by all lanes.
`timescale 1ns / 1ps
module matinv_div
  import matinv_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  num_t num_i [NLANE],
  input  den_t den_i,
  output quo_t q_o   [NLANE],
  output logic ovf_o [NLANE]
);

  den_t den_r [NUM_W];
  num_t num_r [NUM_W][NLANE];
  den_t rem_r [NUM_W][NLANE];
  quo_t q_r   [NUM_W][NLANE];
  logic ovf_r [NUM_W][NLANE];

  den_t den_nxt [NUM_W];
  num_t num_nxt [NUM_W][NLANE];
  den_t rem_nxt [NUM_W][NLANE];
  quo_t q_nxt   [NUM_W][NLANE];
  logic ovf_nxt [NUM_W][NLANE];

  always_comb begin
    logic [DEN_W:0] trial;
    den_t           den_p;
    num_t           num_p;
    den_t           rem_p;
    quo_t           q_p;
    logic           ovf_p;
    logic           ge;
    for (int s = 0; s < NUM_W; s++) begin
      den_p = (s == 0) ? den_i : den_r[(s == 0) ? 0 : s-1];
      den_nxt[s] = den_p;
      for (int l = 0; l < NLANE; l++) begin
        if (s == 0) begin
          num_p = num_i[l];
          rem_p = '0;
          q_p   = '0;
          ovf_p = 1'b0;
        end else begin
          num_p = num_r[s-1][l];
          rem_p = rem_r[s-1][l];
          q_p   = q_r[s-1][l];
          ovf_p = ovf_r[s-1][l];
        end
        trial = {rem_p, num_p[NUM_W-1]};
        ge    = (trial >= {1'b0, den_p});
        rem_nxt[s][l] = ge ? DEN_W'(trial - {1'b0, den_p}) : DEN_W'(trial);
        num_nxt[s][l] = {num_p[NUM_W-2:0], 1'b0};
        q_nxt[s][l]   = {q_p[Q_W-2:0], ge};
        ovf_nxt[s][l] = ovf_p | q_p[Q_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r   <= den_nxt;
      num_r   <= num_nxt;
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      q_o[l]   = q_r[NUM_W-1][l];
      ovf_o[l] = ovf_r[NUM_W-1][l];
    end
  end

endmodule

@@ hdl/matrix_inverse_3x3_core.sv @@
// 3x3 matrix inverse: adjugate over exact determinant, Q4.12 in, Q16.16 out.
// Depends on matinv_pkg and matinv_div.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready   | in_m00 .. in_m22 (16b signed)
//  out     | out_valid / out_ready | out_r00 .. out_r22 (32b signed), out_singular,
//          |                      | out_saturated
//
// One matrix per cycle while the output is not stalled; 5 arithmetic stages,
// 61 divider stages (one quotient bit each), one output register.
// Reset clears only the valid bits.
// A stalled output freezes every stage at once; in_ready follows out_ready
// whenever the output register is full.
`timescale 1ns / 1ps
module matrix_inverse_3x3_core
  import matinv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  ent_t in_m00, input ent_t in_m01, input ent_t in_m02,
  input  ent_t in_m10, input ent_t in_m11, input ent_t in_m12,
  input  ent_t in_m20, input ent_t in_m21, input ent_t in_m22,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_r00, output res_t out_r01, output res_t out_r02,
  output res_t out_r10, output res_t out_r11, output res_t out_r12,
  output res_t out_r20, output res_t out_r21, output res_t out_r22,
  output logic out_singular,
  output logic out_saturated
);

  logic en;
  logic [4:0]       fv_r;
  logic [NUM_W-1:0] dv_r;
  logic             out_valid_r;

  prod_t prod_r [NPROD];
  ent_t  a1_r, b1_r, c1_r, a2_r, b2_r, c2_r;
  adj_t  adj2_r [NLANE];
  adj_t  adj3_r [NLANE];
  adj_t  adj4_r [NLANE];
  det_t  dp_r   [3];
  det_t  det_r;
  num_t  num_r  [NLANE];
  den_t  den_r;
  side_t side5_r;
  side_t side_r [NUM_W];

  quo_t  q_w   [NLANE];
  logic  ovf_w [NLANE];

  res_t  res_r [NLANE];
  logic  singular_r, saturated_r;
  res_t  res_nxt [NLANE];
  logic  saturated_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r        <= '0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      fv_r        <= {fv_r[3:0], in_valid};
      dv_r        <= {dv_r[NUM_W-2:0], fv_r[4]};
      out_valid_r <= dv_r[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products of entry pairs
      prod_r[0]  <= in_m11 * in_m22;  prod_r[1]  <= in_m12 * in_m21;
      prod_r[2]  <= in_m02 * in_m21;  prod_r[3]  <= in_m01 * in_m22;
      prod_r[4]  <= in_m01 * in_m12;  prod_r[5]  <= in_m02 * in_m11;
      prod_r[6]  <= in_m12 * in_m20;  prod_r[7]  <= in_m10 * in_m22;
      prod_r[8]  <= in_m00 * in_m22;  prod_r[9]  <= in_m02 * in_m20;
      prod_r[10] <= in_m02 * in_m10;  prod_r[11] <= in_m00 * in_m12;
      prod_r[12] <= in_m10 * in_m21;  prod_r[13] <= in_m11 * in_m20;
      prod_r[14] <= in_m01 * in_m20;  prod_r[15] <= in_m00 * in_m21;
      prod_r[16] <= in_m00 * in_m11;  prod_r[17] <= in_m01 * in_m10;
      a1_r <= in_m00;
      b1_r <= in_m01;
      c1_r <= in_m02;
      // cofactors
      for (int k = 0; k < NLANE; k++) begin
        adj2_r[k] <= ADJ_W'(prod_r[2*k]) - ADJ_W'(prod_r[2*k+1]);
      end
      a2_r <= a1_r;
      b2_r <= b1_r;
      c2_r <= c1_r;
      // determinant terms
      dp_r[0] <= DET_W'(a2_r) * DET_W'(adj2_r[0]);
      dp_r[1] <= DET_W'(b2_r) * DET_W'(adj2_r[3]);
      dp_r[2] <= DET_W'(c2_r) * DET_W'(adj2_r[6]);
      adj3_r  <= adj2_r;
      // determinant
      det_r  <= dp_r[0] + dp_r[1] + dp_r[2];
      adj4_r <= adj3_r;
      // sign and singular flags, delayed alongside the divider
      side_r[0] <= side5_r;
      for (int s = 1; s < NUM_W; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [NMAG_W-1:0] nmag;
    logic [DMAG_W-1:0] dmag;
    if (en) begin
      dmag = det_r[DET_W-1] ? DMAG_W'(-det_r) : DMAG_W'(det_r);
      den_r <= {dmag, 1'b0};
      side5_r.singular <= (det_r == '0);
      for (int k = 0; k < NLANE; k++) begin
        nmag = adj4_r[k][ADJ_W-1] ? NMAG_W'(-adj4_r[k]) : NMAG_W'(adj4_r[k]);
        num_r[k] <= {nmag, {FRAC_SH{1'b0}}} + NUM_W'(dmag);
        side5_r.neg[k] <= adj4_r[k][ADJ_W-1] ^ det_r[DET_W-1];
      end
    end
  end

  matinv_div u_div (
    .clk   (clk),
    .en    (en),
    .num_i (num_r),
    .den_i (den_r),
    .q_o   (q_w),
    .ovf_o (ovf_w)
  );

  always_comb begin
    saturated_nxt = 1'b0;
    for (int k = 0; k < NLANE; k++) begin
      if (side_r[NUM_W-1].singular) begin
        res_nxt[k] = '0;
      end else if (!side_r[NUM_W-1].neg[k]) begin
        if (ovf_w[k] || (q_w[k] > POS_LIM)) begin
          res_nxt[k]    = POS_MAX;
          saturated_nxt = 1'b1;
        end else begin
          res_nxt[k] = OUT_W'(q_w[k]);
        end
      end else begin
        if (ovf_w[k] || (q_w[k] > NEG_LIM)) begin
          res_nxt[k]    = NEG_MIN;
          saturated_nxt = 1'b1;
        end else begin
          res_nxt[k] = OUT_W'(-q_w[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r       <= res_nxt;
      singular_r  <= side_r[NUM_W-1].singular;
      saturated_r <= saturated_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_r00       = res_r[0];
  assign out_r01       = res_r[1];
  assign out_r02       = res_r[2];
  assign out_r10       = res_r[3];
  assign out_r11       = res_r[4];
  assign out_r12       = res_r[5];
  assign out_r20       = res_r[6];
  assign out_r21       = res_r[7];
  assign out_r22       = res_r[8];
  assign out_singular  = singular_r;
  assign out_saturated = saturated_r;

endmodule

@@ hdl/matinv_chk.sv @@
// Port-level checks for matrix_inverse_3x3_core, attached by bind.
// Depends on matinv_pkg.
`timescale 1ns / 1ps
module matinv_chk
  import matinv_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input res_t out_r00, input res_t out_r01, input res_t out_r02,
  input res_t out_r10, input res_t out_r11, input res_t out_r12,
  input res_t out_r20, input res_t out_r21, input res_t out_r22,
  input logic out_singular,
  input logic out_saturated
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_r00) && $stable(out_singular))
    else $error("stalled result changed");

  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> !out_saturated && out_r00 == 0 && out_r01 == 0 &&
    out_r02 == 0 && out_r10 == 0 && out_r11 == 0 && out_r12 == 0 &&
    out_r20 == 0 && out_r21 == 0 && out_r22 == 0)
    else $error("singular request with nonzero result");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix_inverse_3x3_core matinv_chk u_chk (.*);

@@ test/tb_matrix_inverse_3x3_core.sv @@
// Self-checking testbench for matrix_inverse_3x3_core: directed and random 3x3
// matrices, inverse predicted by exact integer adjugate/determinant arithmetic.
// Depends on matinv_pkg and matrix_inverse_3x3_core.
`timescale 1ns / 1ps
module tb_matrix_inverse_3x3_core
  import matinv_pkg::*;
();

  typedef ent_t mat_t [9];
  typedef struct {
    res_t r [9];
    logic singular;
    logic saturated;
  } inv_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ent_t in_m00, in_m01, in_m02, in_m10, in_m11, in_m12, in_m20, in_m21, in_m22;
  logic out_valid;
  logic out_ready;
  res_t out_r00, out_r01, out_r02, out_r10, out_r11, out_r12, out_r20, out_r21, out_r22;
  logic out_singular;
  logic out_saturated;

  inv_t inverse_q [$];
  int   fail_count;
  int   burst_left;

  matrix_inverse_3x3_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic res_t div_q16(longint num, longint den, ref logic sat);
    longint unsigned n, d, q;
    logic neg;
    n = mag64(num);
    d = mag64(den);
    neg = (num < 0) != (den < 0);
    q = ((n << FRAC_SH) + d) / (d << 1);
    if (!neg) begin
      if (q > 64'h7FFFFFFF) begin
        q = 64'h7FFFFFFF;
        sat = 1'b1;
      end
      return res_t'(q);
    end
    if (q > 64'h80000000) begin
      q = 64'h80000000;
      sat = 1'b1;
    end
    return res_t'(-q);
  endfunction

  function automatic inv_t predict_inverse(mat_t m);
    longint a, b, c, d, e, f, g, h, i, det;
    longint cof [9];
    inv_t res;
    a = m[0]; b = m[1]; c = m[2];
    d = m[3]; e = m[4]; f = m[5];
    g = m[6]; h = m[7]; i = m[8];
    cof[0] = e * i - f * h;
    cof[1] = c * h - b * i;
    cof[2] = b * f - c * e;
    cof[3] = f * g - d * i;
    cof[4] = a * i - c * g;
    cof[5] = c * d - a * f;
    cof[6] = d * h - e * g;
    cof[7] = b * g - a * h;
    cof[8] = a * e - b * d;
    det = a * cof[0] + b * cof[3] + c * cof[6];
    res.saturated = 1'b0;
    res.singular = (det == 0);
    for (int k = 0; k < 9; k++)
      res.r[k] = res.singular ? '0 : div_q16(cof[k], det, res.saturated);
    return res;
  endfunction

  task automatic send_matrix(mat_t m);
    in_valid <= 1'b1;
    {in_m00, in_m01, in_m02} <= {m[0], m[1], m[2]};
    {in_m10, in_m11, in_m12} <= {m[3], m[4], m[5]};
    {in_m20, in_m21, in_m22} <= {m[6], m[7], m[8]};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    inverse_q.insert(inverse_q.size(), predict_inverse(m));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(0, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic ent_t rand_ent(int sel);
    case (sel)
      0: return ent_t'($urandom);
      1: return ent_t'($urandom_range(0, 255)) - ent_t'(128);
      2: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
      default: return ent_t'($urandom_range(0, 8191)) - ent_t'(4096);
    endcase
  endfunction

  task automatic test_directed();
    mat_t m;
    m = '{16'sd4096, 0, 0, 0, 16'sd4096, 0, 0, 0, 16'sd4096};
    send_matrix(m);
    m = '{-16'sd4096, 0, 0, 0, -16'sd4096, 0, 0, 0, -16'sd4096};
    send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(m);
    m = '{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};
    send_matrix(m);
    m = '{-16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, -16'sd1};
    send_matrix(m);
    m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
    send_matrix(m);
    m = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
    send_matrix(m);
    m = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
          16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    send_matrix(m);
    m = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
          16'sh8000, 16'sh7FFF, 16'sh7FFF};
    send_matrix(m);
    m = '{0, 16'sd4096, 0, 0, 0, 16'sd4096, 16'sd4096, 0, 0};
    send_matrix(m);
    m = '{16'sd3, 16'sd1, 0, 16'sd1, 16'sd3, 0, 0, 0, 16'sd2};
    send_matrix(m);
    m = '{16'sd1, 16'sd2, 16'sd3, 16'sd2, 16'sd4, 16'sd6, 16'sd7, 16'sd8, 16'sd9};
    send_matrix(m);
    m = '{16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd5};
    send_matrix(m);
    m = '{16'sh8000, 16'sh8000, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 0, 16'sh8000};
    send_matrix(m);
    m = '{16'sd4096, 16'sd2048, -16'sd1024, 16'sd300, -16'sd4096, 16'sd77,
          16'sd5, 16'sd9, 16'sd4096};
    send_matrix(m);
  endtask

  task automatic test_random_general(int count);
    mat_t m;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 3);
      foreach (m[k]) m[k] = rand_ent(sel);
      if (sel == 3 && $urandom_range(0, 1)) begin
        m[0] += 16'sd8192; m[4] += 16'sd8192; m[8] += 16'sd8192;
      end
      send_matrix(m);
    end
  endtask

  task automatic test_random_singular(int count);
    mat_t m;
    int src, dst, by_row;
    for (int n = 0; n < count; n++) begin
      foreach (m[k]) m[k] = rand_ent($urandom_range(0, 3));
      src = $urandom_range(0, 2);
      dst = (src + $urandom_range(1, 2)) % 3;
      by_row = $urandom_range(0, 1);
      for (int j = 0; j < 3; j++)
        if (by_row != 0) m[dst*3+j] = m[src*3+j];
        else m[j*3+dst] = m[j*3+src];
      send_matrix(m);
    end
  endtask

  task automatic test_near_singular(int count);
    mat_t m;
    for (int n = 0; n < count; n++) begin
      foreach (m[k]) m[k] = rand_ent(1);
      for (int j = 0; j < 3; j++) m[6+j] = m[j] + m[3+j] + ent_t'($urandom_range(0, 1));
      send_matrix(m);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      int ph;
      ph = int'(($time / 10) % 4000);
      if (ph < 600) out_ready <= 1'b1;
      else if (ph < 1200) out_ready <= (ph % 7) != 0;
      else if (ph < 1400) out_ready <= (ph % 9) == 0;
      else out_ready <= $urandom_range(0, 3) != 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (inverse_q.size() == 0) begin
        $error("unexpected result");
        fail_count++;
      end else begin
        inv_t ex;
        res_t got [9];
        ex = inverse_q.pop_front();
        got = '{out_r00, out_r01, out_r02, out_r10, out_r11, out_r12,
                out_r20, out_r21, out_r22};
        for (int k = 0; k < 9; k++)
          if (got[k] !== ex.r[k]) begin
            $error("r%0d%0d exp %0d got %0d", k / 3, k % 3, ex.r[k], got[k]);
            fail_count++;
          end
        if (out_singular !== ex.singular) begin
          $error("singular exp %0b got %0b", ex.singular, out_singular);
          fail_count++;
        end
        if (out_saturated !== ex.saturated) begin
          $error("saturated exp %0b got %0b", ex.saturated, out_saturated);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_m00, in_m01, in_m02, in_m10, in_m11, in_m12, in_m20, in_m21, in_m22} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_general(1300);
    test_random_singular(300);
    test_near_singular(250);
    in_valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && inverse_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/matinv_pkg.sv
hdl/matinv_div.sv
hdl/matrix_inverse_3x3_core.sv
hdl/matinv_chk.sv
test/tb_matrix_inverse_3x3_core.sv
